/* hdl/crfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfs_pkg: shared types and constants of the register file with status
// Access kind and size codes, field widths and status register bit positions.
// ----------------------------------------------------------------------------
package crfs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned MASK_W    = 3;

  typedef logic [2:0]           kind_t;
  typedef logic [1:0]           size_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [DATA_W-1:0]    word_t;

  // Access kinds
  localparam kind_t KIND_RD_DATA = 3'd0;
  localparam kind_t KIND_WR_DATA = 3'd1;
  localparam kind_t KIND_RD_ADDR = 3'd2;
  localparam kind_t KIND_WR_ADDR = 3'd3;
  localparam kind_t KIND_RD_CCR  = 3'd4;
  localparam kind_t KIND_RD_SR   = 3'd5;
  localparam kind_t KIND_WR_CCR  = 3'd6;
  localparam kind_t KIND_WR_SR   = 3'd7;

  // Operand sizes; any other code acts as long
  localparam size_t SIZE_BYTE = 2'd0;
  localparam size_t SIZE_WORD = 2'd1;
  localparam size_t SIZE_LONG = 2'd2;

  // Status register layout
  localparam int unsigned SR_MASK_LSB  = 8;
  localparam int unsigned SR_SUP_BIT   = 13;
  localparam int unsigned SR_TRACE_BIT = 15;
  localparam int unsigned SR_W         = 16;

endpackage

/* hdl/crfs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfs_if: access and result channels of the register file with status
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface crfs_in_if;
  import crfs_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    kind;
  size_t    size;
  reg_idx_t reg_number;
  word_t    write_data;

  modport source (output valid, output kind, output size, output reg_number,
                  output write_data, input ready);
  modport sink   (input valid, input kind, input size, input reg_number,
                  input write_data, output ready);
endinterface

interface crfs_out_if;
  import crfs_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

/* hdl/cpu_register_file_with_status.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_register_file_with_status: data, address and status registers
// Eight data registers, eight address registers, inactive stack pointer and
// status register, accessed by byte, word or long with one result per access.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_ch     sink       kind, size, reg_number, write_data
//  out_ch    source     read_data (zero for writes)
//
//  One access per cycle sustained while out_ch is not stalled; each result
//  passes through the input register, then the result register.
//  Register state is updated when an access moves from the input register
//  into the result register, so back-to-back accesses see earlier writes.
//  Synchronous active-low reset clears all registers and flags.
//  A stalled result holds the result register and the input register; in_ch
//  stays ready while the input register is empty or about to advance.
// ----------------------------------------------------------------------------
module cpu_register_file_with_status (
  input  logic            clk,
  input  logic            rst_n,
  crfs_in_if.sink         in_ch,
  crfs_out_if.source      out_ch
);
  import crfs_pkg::*;

  // Input register
  logic     s1_valid_r;
  kind_t    s1_kind_r;
  size_t    s1_size_r;
  reg_idx_t s1_reg_r;
  word_t    s1_wdata_r;

  // Result register
  logic     out_valid_r;
  word_t    out_data_r;
  word_t    out_data_nxt;

  // Architectural state
  word_t             data_r [NUM_REGS];
  word_t             addr_r [NUM_REGS];
  word_t             osp_r;
  logic [FLAG_W-1:0] flags_r;
  logic [MASK_W-1:0] mask_r;
  logic              sup_r;
  logic              trace_r;

  logic  advance;
  logic  exec;
  word_t data_rd;
  word_t addr_rd;
  word_t data_wr_val;
  word_t addr_wr_val;
  word_t sr_val;
  logic  new_sup;

  assign advance      = !out_valid_r || out_ch.ready;
  assign exec         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.read_data = out_data_r;

  assign data_rd = data_r[s1_reg_r];
  assign addr_rd = addr_r[s1_reg_r];
  assign new_sup = s1_wdata_r[SR_SUP_BIT];

  assign sr_val = {{(DATA_W-SR_W){1'b0}}, trace_r, 1'b0, sup_r, 2'b00, mask_r,
                   3'b000, flags_r};

  always_comb begin
    unique case (s1_size_r)
      SIZE_BYTE: data_wr_val = {data_rd[DATA_W-1:8], s1_wdata_r[7:0]};
      SIZE_WORD: data_wr_val = {data_rd[DATA_W-1:16], s1_wdata_r[15:0]};
      default:   data_wr_val = s1_wdata_r;
    endcase
  end

  always_comb begin
    unique case (s1_size_r)
      SIZE_BYTE: addr_wr_val = {{(DATA_W-8){s1_wdata_r[7]}}, s1_wdata_r[7:0]};
      SIZE_WORD: addr_wr_val = {{(DATA_W-16){s1_wdata_r[15]}}, s1_wdata_r[15:0]};
      default:   addr_wr_val = s1_wdata_r;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    unique case (s1_kind_r)
      KIND_RD_DATA: begin
        unique case (s1_size_r)
          SIZE_BYTE: out_data_nxt = {{(DATA_W-8){1'b0}}, data_rd[7:0]};
          SIZE_WORD: out_data_nxt = {{(DATA_W-16){1'b0}}, data_rd[15:0]};
          default:   out_data_nxt = data_rd;
        endcase
      end
      KIND_RD_ADDR: begin
        unique case (s1_size_r)
          SIZE_BYTE: out_data_nxt = {{(DATA_W-8){addr_rd[7]}}, addr_rd[7:0]};
          SIZE_WORD: out_data_nxt = {{(DATA_W-16){addr_rd[15]}}, addr_rd[15:0]};
          default:   out_data_nxt = addr_rd;
        endcase
      end
      KIND_RD_CCR:  out_data_nxt = {{(DATA_W-FLAG_W){1'b0}}, flags_r};
      KIND_RD_SR:   out_data_nxt = sr_val;
      KIND_WR_DATA,
      KIND_WR_ADDR,
      KIND_WR_CCR,
      KIND_WR_SR:   out_data_nxt = '0;
      default:      out_data_nxt = '0;
    endcase
  end

  // Input register: load on transfer, drop when passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r  <= in_ch.kind;
      s1_size_r  <= in_ch.size;
      s1_reg_r   <= in_ch.reg_number;
      s1_wdata_r <= in_ch.write_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Register state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        data_r[i] <= '0;
        addr_r[i] <= '0;
      end
      osp_r   <= '0;
      flags_r <= '0;
      mask_r  <= '0;
      sup_r   <= 1'b0;
      trace_r <= 1'b0;
    end else if (exec) begin
      unique case (s1_kind_r)
        KIND_WR_DATA: data_r[s1_reg_r] <= data_wr_val;
        KIND_WR_ADDR: addr_r[s1_reg_r] <= addr_wr_val;
        KIND_WR_CCR:  flags_r <= s1_wdata_r[FLAG_W-1:0];
        KIND_WR_SR: begin
          flags_r <= s1_wdata_r[FLAG_W-1:0];
          mask_r  <= s1_wdata_r[SR_MASK_LSB +: MASK_W];
          sup_r   <= new_sup;
          trace_r <= s1_wdata_r[SR_TRACE_BIT];
          // Mode change: swap active and inactive stack pointers
          if (new_sup != sup_r) begin
            addr_r[NUM_REGS-1] <= osp_r;
            osp_r              <= addr_r[NUM_REGS-1];
          end
        end
        KIND_RD_DATA,
        KIND_RD_ADDR,
        KIND_RD_CCR,
        KIND_RD_SR: ;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed access produced no result");

  a_write_returns_zero: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (s1_kind_r == KIND_WR_DATA || s1_kind_r == KIND_WR_ADDR ||
             s1_kind_r == KIND_WR_CCR || s1_kind_r == KIND_WR_SR)
    |=> out_data_r == '0)
    else $error("write access returned nonzero data");

  a_sp_swap: assert property (@(posedge clk) disable iff (!rst_n)
    exec && s1_kind_r == KIND_WR_SR && new_sup != sup_r
    |=> addr_r[NUM_REGS-1] == $past(osp_r) && osp_r == $past(addr_r[NUM_REGS-1]))
    else $error("stack pointers not swapped on mode change");

  a_sr_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    exec && s1_kind_r == KIND_RD_SR
    |=> out_data_r[DATA_W-1:SR_W] == '0 && out_data_r[14] == 1'b0 &&
        out_data_r[12:11] == 2'b00 && out_data_r[7:5] == 3'b000)
    else $error("undefined status bits read as nonzero");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule
